FILE: hw/rtl/lds_pkg.sv
// package: shared types and constants of the diophantine solver
`default_nettype none
package lds_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned MAG_W  = 33;
    localparam int unsigned COEF_W = 64;
    localparam int unsigned SOL_W  = 63;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_CHECK,
        ST_DIV,
        ST_MUL_S,
        ST_MUL_T,
        ST_GDIV,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/lds_if.sv
// interfaces: valid/ready channels for input and result items
`default_nettype none
interface lds_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] rhs_c;
    modport source (output valid, coef_a, coef_b, rhs_c, input ready);
    modport sink (input valid, coef_a, coef_b, rhs_c, output ready);
endinterface

interface lds_out_if;
    logic               valid;
    logic               ready;
    logic               solvable;
    logic signed [62:0] sol_x;
    logic signed [62:0] sol_y;
    logic        [31:0] gcd_val;
    modport source (output valid, solvable, sol_x, sol_y, gcd_val, input ready);
    modport sink (input valid, solvable, sol_x, sol_y, gcd_val, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/linear_diophantine_solver_top.sv
// top level: sequenced extended euclid with one shared divider and multiplier
// each euclid step: a check state, a restoring divide and two multiply states (s, then t)
// the final c/g division reuses the same serial divider; both-zero input goes from check straight to output
// one item at a time: in.ready is high only in idle and low while an item is in work
// reset: rst_n asynchronous active low, returns the sequencer to idle
`default_nettype none
module linear_diophantine_solver_top
    import lds_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lds_in_if.sink    in_ch,
    lds_out_if.source out_ch
);
    state_t state_reg, state_next;

    // euclid registers; s and t stay small, so 34 signed bits keep them exact
    logic [MAG_W-1:0]        r0_reg, r1_reg, mc_reg;
    logic signed [MAG_W:0]   s0_reg, s1_reg, t0_reg, t1_reg;
    logic                    a_neg_reg, b_neg_reg, c_neg_reg;

    // shared serial divider: restoring, one quotient bit per cycle
    logic [MAG_W-1:0] dv_num_reg, dv_den_reg, dv_quo_reg;
    logic [MAG_W:0]   dv_rem_reg;
    logic [5:0]       dv_cnt_reg;
    logic [MAG_W:0]   dv_trial;
    logic [MAG_W:0]   dv_diff;

    // shared multiplier operands and signed scale factor c/g
    logic signed [MAG_W:0]    mul_a;
    logic signed [MAG_W:0]    mul_b;
    logic signed [2*MAG_W+1:0] mul_full;
    logic signed [MAG_W:0]    k_reg;

    logic             sol_reg;
    logic [SOL_W-1:0] x_reg, y_reg;
    logic [DATA_W-1:0] g_reg;

    assign dv_trial = {dv_rem_reg[MAG_W-1:0], dv_num_reg[MAG_W-1]};
    assign dv_diff  = dv_trial - {1'b0, dv_den_reg};

    // operand selection for the one multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_S:   begin mul_a = $signed({1'b0, dv_quo_reg}); mul_b = s1_reg; end
            ST_MUL_T:   begin mul_a = $signed({1'b0, dv_quo_reg}); mul_b = t1_reg; end
            ST_SCALE_X: begin mul_a = s0_reg; mul_b = k_reg; end
            ST_SCALE_Y: begin mul_a = t0_reg; mul_b = k_reg; end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_full = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_ch.valid) state_next = ST_ABS;
            ST_ABS:     state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (r0_reg == '0 && r1_reg == '0) state_next = ST_OUT;
                else if (r1_reg == '0) state_next = ST_GDIV;
                else state_next = ST_DIV;
            end
            ST_DIV:     if (dv_cnt_reg == 6'd0) state_next = ST_MUL_S;
            ST_MUL_S:   state_next = ST_MUL_T;
            ST_MUL_T:   state_next = ST_CHECK;
            ST_GDIV:
            begin
                if (dv_cnt_reg == 6'd0)
                    state_next = (dv_rem_reg == '0) ? ST_SCALE_X : ST_OUT;
            end
            ST_SCALE_X: state_next = ST_SCALE_Y;
            ST_SCALE_Y: state_next = ST_OUT;
            ST_OUT:     if (out_ch.ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    r0_reg    <= {in_ch.coef_a[31], in_ch.coef_a};
                    r1_reg    <= {in_ch.coef_b[31], in_ch.coef_b};
                    mc_reg    <= {in_ch.rhs_c[31], in_ch.rhs_c};
                    a_neg_reg <= in_ch.coef_a[31];
                    b_neg_reg <= in_ch.coef_b[31];
                    c_neg_reg <= in_ch.rhs_c[31];
                end
            end
            ST_ABS:
            begin
                // magnitudes; sign-extended to 33 bits so -2^31 is exact
                if (a_neg_reg) r0_reg <= '0 - r0_reg;
                if (b_neg_reg) r1_reg <= '0 - r1_reg;
                if (c_neg_reg) mc_reg <= '0 - mc_reg;
                s0_reg  <= 34'sd1;
                s1_reg  <= '0;
                t0_reg  <= '0;
                t1_reg  <= 34'sd1;
                sol_reg <= 1'b0;
                x_reg   <= '0;
                y_reg   <= '0;
                g_reg   <= '0;
            end
            ST_CHECK:
            begin
                dv_cnt_reg <= 6'(MAG_W);
                dv_rem_reg <= '0;
                dv_quo_reg <= '0;
                if (r0_reg == '0 && r1_reg == '0)
                    sol_reg <= (mc_reg == '0);
                else if (r1_reg == '0)
                begin
                    g_reg      <= r0_reg[DATA_W-1:0];
                    dv_num_reg <= mc_reg;
                    dv_den_reg <= r0_reg;
                end
                else
                begin
                    dv_num_reg <= r0_reg;
                    dv_den_reg <= r1_reg;
                end
            end
            ST_DIV, ST_GDIV:
            begin
                if (dv_cnt_reg != 6'd0)
                begin
                    dv_cnt_reg <= dv_cnt_reg - 6'd1;
                    dv_num_reg <= {dv_num_reg[MAG_W-2:0], 1'b0};
                    if (!dv_diff[MAG_W])
                    begin
                        dv_rem_reg <= dv_diff;
                        dv_quo_reg <= {dv_quo_reg[MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg <= dv_trial;
                        dv_quo_reg <= {dv_quo_reg[MAG_W-2:0], 1'b0};
                    end
                end
                else if (state_reg == ST_DIV)
                begin
                    // remainder of the step becomes the new r1
                    r0_reg <= r1_reg;
                    r1_reg <= dv_rem_reg[MAG_W-1:0];
                end
                else
                begin
                    sol_reg <= (dv_rem_reg == '0);
                    k_reg   <= c_neg_reg ? -$signed({1'b0, dv_quo_reg})
                                         :  $signed({1'b0, dv_quo_reg});
                end
            end
            ST_MUL_S:
            begin
                s0_reg <= s1_reg;
                s1_reg <= s0_reg - mul_full[MAG_W:0];
            end
            ST_MUL_T:
            begin
                t0_reg <= t1_reg;
                t1_reg <= t0_reg - mul_full[MAG_W:0];
            end
            ST_SCALE_X:
            begin
                x_reg <= a_neg_reg ? SOL_W'(-mul_full[COEF_W-1:0])
                                   : mul_full[SOL_W-1:0];
            end
            ST_SCALE_Y:
            begin
                y_reg <= b_neg_reg ? SOL_W'(-mul_full[COEF_W-1:0])
                                   : mul_full[SOL_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = (state_reg == ST_OUT);
    assign out_ch.solvable = sol_reg;
    assign out_ch.sol_x    = $signed(x_reg);
    assign out_ch.sol_y    = $signed(y_reg);
    assign out_ch.gcd_val  = g_reg;
endmodule
`default_nettype wire
